// ===== hdl/bbad_pkg.sv =====
`default_nettype none
package bbad_pkg;

  localparam int ADDR_W      = 14;
  localparam int POS_W       = 3;
  localparam int COORD_W     = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  localparam logic [ADDR_W-1:0] ADDR_OUT = 14'h3FFF;

  // position of a coordinate against the image borders
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic x_near_right;
    logic x_past_right;
    logic x_near_left;
    logic x_past_left;
    logic y_near_bottom;
    logic y_past_bottom;
    logic y_near_top;
    logic y_past_top;
  } edge_t;

  typedef struct packed {
    logic [POS_W-1:0] tl;
    logic [POS_W-1:0] tr;
    logic [POS_W-1:0] bl;
    logic [POS_W-1:0] br;
  } pos_t;

endpackage
`default_nettype wire

// ===== hdl/bilinear_bank_address_decode_core.sv =====
// channel | dir | beat fields (tdata, lowest bit up)
// in_     | in  | x_coord[15:0], y_coord[31:16]
// out_    | out | addr_odd_odd, addr_odd_even, addr_even_odd, addr_even_even (14 each),
//         |     | pos_top_left, pos_top_right, pos_bottom_left, pos_bottom_right (3 each),
//         |     | row_is_odd, group_is_odd, zero pad to 72
//
// six register stages, one beat per cycle while the output is not stalled
// stage 1 pixel index multiply, stages 2-4 divide by groups per row, 5 bank row address,
// 6 bank select and border override (output register)
// the whole pipeline advances when the output register is empty or being taken
// rst_n clears the valid bits only
`default_nettype none
module bilinear_bank_address_decode_core
  import bbad_pkg::*;
#(
  parameter int IMG_WIDTH  = 320,
  parameter int IMG_HEIGHT = 240,
  parameter int FRAC_BITS  = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // x_coord, y_coord
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // oo, oe, eo, ee, tl, tr, bl, br, rodd, godd
);

  localparam int ONE         = 1 << FRAC_BITS;
  localparam int GPR         = IMG_WIDTH / 8;
  localparam int GPBR        = IMG_WIDTH / 16;
  localparam int DIV_SH      = 22;
  localparam int DIV_M       = (1 << DIV_SH) / GPR;
  localparam int X_RIGHT_LO  = (IMG_WIDTH - 8) * ONE;
  localparam int X_RIGHT_HI  = IMG_WIDTH * ONE;
  localparam int Y_BOTTOM_LO = (IMG_HEIGHT - 1) * ONE;
  localparam int Y_BOTTOM_HI = IMG_HEIGHT * ONE;
  localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'(ONE - 1);
  localparam logic [POS_W-1:0]   W_LO      = POS_W'(IMG_WIDTH % 8);

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: pixel index and border flags
  logic signed [COORD_W-1:0] x_s, y_s, xi, yi;
  int                        xs, ys;
  logic [16:0]               pix_nxt;
  edge_t                     edge_nxt;
  logic                      whole_nxt;

  logic        s1_v_r;
  logic [16:0] s1_pix_r;
  edge_t       s1_edge_r;
  logic        s1_whole_r;

  always_comb begin
    x_s = signed'(in_tdata[COORD_W-1:0]);
    y_s = signed'(in_tdata[2*COORD_W-1:COORD_W]);
    xs  = int'(x_s);
    ys  = int'(y_s);
    xi  = x_s >>> FRAC_BITS;
    yi  = y_s[COORD_W-1] ? '1 : (y_s >>> FRAC_BITS);
    pix_nxt = {yi[COORD_W-1], yi} * 17'(IMG_WIDTH) + {xi[COORD_W-1], xi};
    whole_nxt = ((in_tdata[COORD_W-1:0] & FRAC_MASK) == '0) &&
                ((in_tdata[2*COORD_W-1:COORD_W] & FRAC_MASK) == '0);
    edge_nxt.x_neg         = x_s[COORD_W-1];
    edge_nxt.y_neg         = y_s[COORD_W-1];
    edge_nxt.x_near_right  = (xs >= X_RIGHT_LO) && (xs < X_RIGHT_HI);
    edge_nxt.x_past_right  = xs >= X_RIGHT_HI;
    edge_nxt.x_near_left   = (xs < 0) && (xs > -ONE);
    edge_nxt.x_past_left   = xs <= -ONE;
    edge_nxt.y_near_bottom = (ys >= Y_BOTTOM_LO) && (ys < Y_BOTTOM_HI);
    edge_nxt.y_past_bottom = ys >= Y_BOTTOM_HI;
    edge_nxt.y_near_top    = (ys < 0) && (ys > -ONE);
    edge_nxt.y_past_top    = ys <= -ONE;
  end

  // stage 2: reciprocal estimate of group / GPR, pixel slots
  logic [35:0]       qprod;
  pos_t              pos_nxt;
  logic [POS_W-1:0]  p0;

  logic              s2_v_r;
  logic [ADDR_W-1:0] s2_grp_r;
  logic [ADDR_W-1:0] s2_q_r;
  edge_t             s2_edge_r;
  pos_t              s2_pos_r;

  always_comb begin
    qprod = 36'(s1_pix_r[16:3]) * 36'(DIV_M);
    p0    = s1_pix_r[2:0];
    if (s1_edge_r.x_neg) begin
      pos_nxt = '{tl: 3'd7, tr: 3'd0, bl: 3'd7, br: 3'd0};
    end else if (s1_whole_r) begin
      pos_nxt = '{tl: p0, tr: p0, bl: p0, br: p0};
    end else begin
      pos_nxt = '{tl: p0, tr: p0 + 3'd1, bl: p0 + W_LO, br: p0 + W_LO + 3'd1};
    end
  end

  // stage 3: remainder before correction
  logic              s3_v_r;
  logic [ADDR_W-1:0] s3_q_r;
  logic [ADDR_W-1:0] s3_rem_r;
  logic              s3_grp0_r;
  edge_t             s3_edge_r;
  pos_t              s3_pos_r;

  // stage 4: estimate is low by at most one
  logic              s4_v_r;
  logic [ADDR_W-1:0] s4_rows_r;
  logic [ADDR_W-1:0] s4_cols_r;
  logic              s4_grp0_r;
  edge_t             s4_edge_r;
  pos_t              s4_pos_r;

  // stage 5: base word address in the top row's bank
  logic              s5_v_r;
  logic [ADDR_W-1:0] s5_a_r;
  logic              s5_rodd_r;
  logic              s5_godd_r;
  edge_t             s5_edge_r;
  pos_t              s5_pos_r;

  // stage 6: bank selection and border override
  logic [ADDR_W-1:0] oo, oe, eo, ee, a_m1, b, b_m1;

  always_comb begin
    a_m1 = s5_a_r - 14'd1;
    b    = s5_a_r + 14'(GPBR);
    b_m1 = b - 14'd1;
    if (s5_rodd_r) begin
      oo = s5_a_r;
      eo = s5_a_r;
      oe = s5_godd_r ? s5_a_r : a_m1;
      ee = oe;
    end else begin
      eo = s5_a_r;
      ee = s5_godd_r ? s5_a_r : a_m1;
      oo = b;
      oe = s5_godd_r ? b : b_m1;
    end
    if (s5_edge_r.x_near_right) begin
      oo = ADDR_OUT; eo = ADDR_OUT;
    end else if (s5_edge_r.x_past_right || s5_edge_r.x_past_left) begin
      oo = ADDR_OUT; oe = ADDR_OUT; eo = ADDR_OUT; ee = ADDR_OUT;
    end else if (s5_edge_r.x_near_left) begin
      oe = ADDR_OUT; ee = ADDR_OUT;
    end
    if (s5_edge_r.y_near_bottom) begin
      oo = ADDR_OUT; oe = ADDR_OUT;
    end else if (s5_edge_r.y_past_bottom || s5_edge_r.y_past_top) begin
      oo = ADDR_OUT; oe = ADDR_OUT; eo = ADDR_OUT; ee = ADDR_OUT;
    end else if (s5_edge_r.y_near_top) begin
      eo = ADDR_OUT; ee = ADDR_OUT;
    end
  end

  logic out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      s5_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r       <= in_tvalid;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
      s4_v_r       <= s3_v_r;
      s5_v_r       <= s4_v_r;
      out_tvalid_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r   <= pix_nxt;
      s1_edge_r  <= edge_nxt;
      s1_whole_r <= whole_nxt;

      s2_grp_r  <= s1_pix_r[16:3];
      s2_q_r    <= qprod[DIV_SH+ADDR_W-1:DIV_SH];
      s2_edge_r <= s1_edge_r;
      s2_pos_r  <= pos_nxt;

      s3_q_r    <= s2_q_r;
      s3_rem_r  <= s2_grp_r - 14'(s2_q_r * 14'(GPR));
      s3_grp0_r <= s2_grp_r[0];
      s3_edge_r <= s2_edge_r;
      s3_pos_r  <= s2_pos_r;

      if (s3_rem_r >= 14'(GPR)) begin
        s4_rows_r <= s3_q_r + 14'd1;
        s4_cols_r <= s3_rem_r - 14'(GPR);
      end else begin
        s4_rows_r <= s3_q_r;
        s4_cols_r <= s3_rem_r;
      end
      s4_grp0_r <= s3_grp0_r;
      s4_edge_r <= s3_edge_r;
      s4_pos_r  <= s3_pos_r;

      s5_a_r    <= {1'b0, s4_rows_r[ADDR_W-1:1]} * 14'(GPBR)
                   + {1'b0, s4_cols_r[ADDR_W-1:1]} + 14'(s4_grp0_r);
      s5_rodd_r <= !s4_edge_r.y_neg && !s4_rows_r[0];
      s5_godd_r <= !s4_edge_r.x_neg && !s4_grp0_r;
      s5_edge_r <= s4_edge_r;
      s5_pos_r  <= s4_pos_r;

      out_tdata_r <= {2'b00, s5_godd_r, s5_rodd_r,
                      s5_pos_r.br, s5_pos_r.bl, s5_pos_r.tr, s5_pos_r.tl,
                      ee, eo, oe, oo};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

// ===== hdl/bbad_checker.sv =====
`default_nettype none
module bbad_checker
  import bbad_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out beat changed while stalled");

  // an empty output register never blocks the input side
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out beat after reset");

endmodule

bind bilinear_bank_address_decode_core bbad_checker u_bbad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== dv/bank_addr_checker.sv =====
module bank_addr_checker
  import bbad_pkg::*;
#(
  parameter int IMG_WIDTH  = 320,
  parameter int IMG_HEIGHT = 240,
  parameter int FRAC_BITS  = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending,
  output int                     compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int GROUPS    = IMG_WIDTH / 8;
  localparam int BANK_ROW  = IMG_WIDTH / 16;

  // laid out from the top bit down so a cast from out_tdata lines up
  typedef struct packed {
    logic [1:0]        pad;
    logic              godd;
    logic              rodd;
    logic [POS_W-1:0]  br;
    logic [POS_W-1:0]  bl;
    logic [POS_W-1:0]  tr;
    logic [POS_W-1:0]  tl;
    logic [ADDR_W-1:0] ee;
    logic [ADDR_W-1:0] eo;
    logic [ADDR_W-1:0] oe;
    logic [ADDR_W-1:0] oo;
  } neighborhood_t;

  neighborhood_t expected_q[$];

  function automatic neighborhood_t predict_neighborhood(logic signed [COORD_W-1:0] x,
                                                         logic signed [COORD_W-1:0] y);
    int xs, ys, xi, yi, idx, p, g, rows, cols, sum;
    logic [ADDR_W-1:0] a;
    logic whole;
    neighborhood_t r;
    xs = x;
    ys = y;
    xi = xs >>> FRAC_BITS;
    yi = (ys < 0) ? -1 : (ys >>> FRAC_BITS);
    idx = yi * IMG_WIDTH + xi;
    p = idx & 32'h1FFFF;
    whole = (x[FRAC_BITS-1:0] == '0) && (y[FRAC_BITS-1:0] == '0);
    g = (p >> 3) & 32'h3FFF;
    rows = g / GROUPS;
    cols = g % GROUPS;
    r = '0;
    r.godd = (xs < 0) ? 1'b0 : ~g[0];
    r.rodd = (ys < 0) ? 1'b0 : ~rows[0];
    sum = (rows >> 1) * BANK_ROW + (cols >> 1) + (g & 1);
    a = sum[ADDR_W-1:0];

    if (r.rodd) begin
      r.oo = a;
      r.eo = a;
      r.oe = r.godd ? a : a - 1'b1;
      r.ee = r.oe;
    end else begin
      r.eo = a;
      r.ee = r.godd ? a : a - 1'b1;
      sum = a + BANK_ROW;
      r.oo = sum[ADDR_W-1:0];
      r.oe = r.godd ? r.oo : r.oo - 1'b1;
    end

    if (xs < 0) begin
      r.tl = 3'd7;
      r.tr = 3'd0;
      r.bl = 3'd7;
      r.br = 3'd0;
    end else if (whole) begin
      r.tl = p[2:0];
      r.tr = p[2:0];
      r.bl = p[2:0];
      r.br = p[2:0];
    end else begin
      r.tl = p[2:0];
      sum = p + 1;
      r.tr = sum[2:0];
      sum = p + IMG_WIDTH;
      r.bl = sum[2:0];
      sum = p + IMG_WIDTH + 1;
      r.br = sum[2:0];
    end

    // x: right pair off in last word, left pair off left of 0, all four off beyond
    if (xs >= (IMG_WIDTH - 8) * ONE && xs < IMG_WIDTH * ONE) begin
      r.oo = ADDR_OUT;
      r.eo = ADDR_OUT;
    end else if (xs >= IMG_WIDTH * ONE) begin
      r.oo = ADDR_OUT; r.oe = ADDR_OUT; r.eo = ADDR_OUT; r.ee = ADDR_OUT;
    end else if (xs < 0 && xs > -ONE) begin
      r.oe = ADDR_OUT;
      r.ee = ADDR_OUT;
    end else if (xs <= -ONE) begin
      r.oo = ADDR_OUT; r.oe = ADDR_OUT; r.eo = ADDR_OUT; r.ee = ADDR_OUT;
    end

    if (ys >= (IMG_HEIGHT - 1) * ONE && ys < IMG_HEIGHT * ONE) begin
      r.oo = ADDR_OUT;
      r.oe = ADDR_OUT;
    end else if (ys >= IMG_HEIGHT * ONE) begin
      r.oo = ADDR_OUT; r.oe = ADDR_OUT; r.eo = ADDR_OUT; r.ee = ADDR_OUT;
    end else if (ys < 0 && ys > -ONE) begin
      r.eo = ADDR_OUT;
      r.ee = ADDR_OUT;
    end else if (ys <= -ONE) begin
      r.oo = ADDR_OUT; r.oe = ADDR_OUT; r.eo = ADDR_OUT; r.ee = ADDR_OUT;
    end
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    neighborhood_t got, want;
    if (!rst_n) begin
      expected_q.delete();
      fail_count = 0;
      pending = 0;
      compared = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_neighborhood(in_tdata[15:0], in_tdata[31:16]));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = expected_q.pop_front();
          compared++;
          check_field("addr_odd_odd", want.oo, got.oo);
          check_field("addr_odd_even", want.oe, got.oe);
          check_field("addr_even_odd", want.eo, got.eo);
          check_field("addr_even_even", want.ee, got.ee);
          check_field("pos_top_left", want.tl, got.tl);
          check_field("pos_top_right", want.tr, got.tr);
          check_field("pos_bottom_left", want.bl, got.bl);
          check_field("pos_bottom_right", want.br, got.br);
          check_field("row_is_odd", want.rodd, got.rodd);
          check_field("group_is_odd", want.godd, got.godd);
          check_field("tdata pad", want.pad, got.pad);
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== dv/bilinear_bank_address_decode_core_tb.sv =====
module bilinear_bank_address_decode_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbad_pkg::*;

  localparam int IMG_W       = 320;
  localparam int IMG_H       = 240;
  localparam int FRAC        = 5;
  localparam int ONE         = 1 << FRAC;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF    = 12;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int compared;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent = 0;
  int cycle_count = 0;

  bilinear_bank_address_decode_core #(
    .IMG_WIDTH (IMG_W),
    .IMG_HEIGHT(IMG_H),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  bank_addr_checker #(
    .IMG_WIDTH (IMG_W),
    .IMG_HEIGHT(IMG_H),
    .FRAC_BITS (FRAC)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending),
    .compared  (compared)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_coord(input int x, input int y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y[15:0], x[15:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  // half inside the image, the rest in bands around both borders and the full range
  function automatic int pick_coord(int span);
    int v;
    case ($urandom_range(11))
      8, 9:    v = $urandom_range(65535) - 32768;
      6:       v = $urandom_range(span + 2 * ONE, span - 10 * ONE);
      7:       v = $urandom_range(4 * ONE) - 2 * ONE;
      10:      v = -$urandom_range(64 * ONE, 1);
      11:      v = $urandom_range(1023 * ONE);
      default: v = $urandom_range(span - 1);
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    int x, y;
    repeat (count) begin
      x = pick_coord(IMG_W * ONE);
      y = pick_coord(IMG_H * ONE);
      if ($urandom_range(3) == 0) begin
        x = x & ~(ONE - 1);
        y = y & ~(ONE - 1);
      end
      send_coord(x, y);
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bilinear_bank_address_decode_core verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 12; recv_idle_pct = 67; end
        1:       begin send_idle_pct = 67; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      if (phase == 0) begin
        // whole and fractional coordinates, both parities
        send_coord(0, 0);
        send_coord(ONE, ONE);
        send_coord(8 * ONE + 5, ONE + 7);
        send_coord(100 * ONE + 17, 50 * ONE + 3);
        // extremes of both fields
        send_coord(32767, 32767);
        send_coord(-32768, -32768);
        send_coord(32767, -32768);
        send_coord(-32768, 32767);
        // left and top borders
        send_coord(-1, -1);
        send_coord(-5, -5);
        send_coord(-(ONE - 1), 40);
        send_coord(-ONE, 40);
        send_coord(-ONE - 1, 40);
        send_coord(40, -(ONE - 1));
        send_coord(40, -ONE);
        // right border band and beyond
        send_coord((IMG_W - 8) * ONE - 1, 100);
        send_coord((IMG_W - 8) * ONE, 100);
        send_coord(IMG_W * ONE - 1, 100);
        send_coord(IMG_W * ONE, 100);
        // bottom border band and beyond
        send_coord(100, (IMG_H - 1) * ONE - 1);
        send_coord(100, (IMG_H - 1) * ONE);
        send_coord(100, IMG_H * ONE - 1);
        send_coord(100, IMG_H * ONE);
        send_coord(IMG_W * ONE - 1, IMG_H * ONE - 1);
        send_random(493);
      end else begin
        send_random(515);
      end
      drain_results();
    end

    $display("%0d coordinate beats: borders, whole and negative coordinates, full range,",
             beats_sent);
    $display("under three pacing mixes; %0d result beats compared field by field", compared);
    if (fail_count == 0) begin
      $display("bilinear_bank_address_decode_core verification clean");
    end else begin
      $display("bilinear_bank_address_decode_core verification failed");
    end
    $finish;
  end

endmodule
